FILE: design/per_position_quality_histogram_macros.svh
// Assertion macros for the per-position quality histogram.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PER_POSITION_QUALITY_HISTOGRAM_MACROS_SVH
`define PER_POSITION_QUALITY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPQH_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ppqh same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PPQH_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ppqh next-cycle check failed");

`endif

FILE: design/ppqh_pkg.sv
// Shared types and codes for the per-position quality histogram.
// No dependencies.
`timescale 1ns / 1ps

package ppqh_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] OFFSET_RESET = 8'd33;

    // Input opcodes
    localparam logic [1:0] OP_BASE  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // Work kinds passed from front to back
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_INC  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       mate2;
        logic       clamped;
        logic       dropped;
    } cmd_ctrl_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

FILE: design/ppqh_fifo.sv
// Small register queue used between front and back and on the result side.
// No dependencies.
`timescale 1ns / 1ps

module ppqh_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  data_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/ppqh_front.sv
// Front end: accepts items, forms scores and bin addresses, keeps read totals.
// Depends on ppqh_pkg.
`timescale 1ns / 1ps

module ppqh_front
    import ppqh_pkg::*;
#(
    parameter int MAX_LEN    = 256,
    parameter int NUM_SCORES = 64,
    parameter int PW         = $clog2(MAX_LEN),
    parameter int SW         = $clog2(NUM_SCORES),
    parameter int LW         = $clog2(MAX_LEN + 1),
    parameter int AW         = 1 + PW + SW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    opcode,
    input  logic          mate,
    input  logic [7:0]    quality_char,
    input  logic          last_in_read,
    input  logic [7:0]    query_position,
    input  logic [5:0]    query_score,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  back_status_t  back_status,
    input  logic          cmd_full,
    output logic          cmd_push,
    output cmd_ctrl_t     cmd_ctrl,
    output logic [AW-1:0] cmd_addr,
    output logic [31:0]   cmd_total,
    output logic [LW-1:0] cmd_maxlen
);

    logic [7:0]    offset_reg;
    logic [LW-1:0] pos_reg;
    logic [LW-1:0] pos_next;
    logic [LW-1:0] maxlen_reg;
    logic [LW-1:0] maxlen_next;
    logic [31:0]   total_reg;
    logic [31:0]   total_next;
    logic          mate2_reg;
    logic          mate2_next;

    logic [8:0]    diff;
    logic          neg;
    logic          high;
    logic [SW-1:0] score;
    logic          drop;
    logic [LW-1:0] pos_inc;
    logic [31:0]   total_inc;
    logic          accept;
    logic          q_ok;
    logic [PW+7:0] qpos_x;
    logic [SW+5:0] qscore_x;

    assign full     = cmd_full || back_status.clearing;
    assign accept   = push && !full;
    assign cmd_push = accept;

    assign diff  = {1'b0, quality_char} - {1'b0, offset_reg};
    assign neg   = diff[8];
    assign high  = !neg && (diff[7:0] >= 8'(NUM_SCORES));
    assign score = neg ? '0 : (high ? SW'(NUM_SCORES - 1) : diff[SW-1:0]);

    // Position saturates at the store depth
    assign drop      = (pos_reg >= LW'(MAX_LEN));
    assign pos_inc   = drop ? pos_reg : pos_reg + 1'b1;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + 1'b1;

    assign q_ok     = (32'(query_position) < 32'(MAX_LEN)) &&
                      (32'(query_score) < 32'(NUM_SCORES));
    assign qpos_x   = (PW + 8)'(query_position);
    assign qscore_x = (SW + 6)'(query_score);

    always_comb
    begin
        pos_next         = pos_reg;
        maxlen_next      = maxlen_reg;
        total_next       = total_reg;
        mate2_next       = mate2_reg;
        cmd_ctrl.kind    = CMD_NONE;
        cmd_ctrl.clamped = 1'b0;
        cmd_ctrl.dropped = 1'b0;
        cmd_addr         = '0;
        if (accept)
        begin
            unique case (opcode)
                OP_BASE:
                begin
                    mate2_next       = mate2_reg | mate;
                    cmd_ctrl.clamped = neg | high;
                    cmd_ctrl.dropped = drop;
                    if (!drop)
                    begin
                        cmd_ctrl.kind = CMD_INC;
                        cmd_addr      = {mate, pos_reg[PW-1:0], score};
                    end
                    pos_next = pos_inc;
                    if (pos_inc > maxlen_reg)
                    begin
                        maxlen_next = pos_inc;
                    end
                    if (last_in_read)
                    begin
                        total_next = total_inc;
                        pos_next   = '0;
                    end
                end
                OP_QUERY:
                begin
                    if (q_ok)
                    begin
                        cmd_ctrl.kind = CMD_READ;
                        cmd_addr      = {mate, qpos_x[PW-1:0], qscore_x[SW-1:0]};
                    end
                end
                OP_EMPTY:
                begin
                    total_next = total_inc;
                    pos_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        cmd_ctrl.mate2 = mate2_next;
    end

    // Totals travel with the item as they stand after it
    assign cmd_total  = total_next;
    assign cmd_maxlen = maxlen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            pos_reg    <= '0;
            maxlen_reg <= '0;
            total_reg  <= '0;
            mate2_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            pos_reg    <= pos_next;
            maxlen_reg <= maxlen_next;
            total_reg  <= total_next;
            mate2_reg  <= mate2_next;
        end
    end

endmodule

FILE: design/ppqh_back.sv
// Back end: histogram memory, clearing pass, and read-modify-write or read of one bin.
// Depends on ppqh_pkg.
`timescale 1ns / 1ps

module ppqh_back
    import ppqh_pkg::*;
#(
    parameter int AW          = 15,
    parameter int COUNT_WIDTH = 32,
    parameter int LW          = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  cmd_ctrl_t     cmd_ctrl,
    input  logic [AW-1:0] cmd_addr,
    input  logic [31:0]   cmd_total,
    input  logic [LW-1:0] cmd_maxlen,
    input  logic          rsp_full,
    output logic          rsp_push,
    output logic [31:0]   rsp_bin,
    output logic [31:0]   rsp_total,
    output logic [LW-1:0] rsp_maxlen,
    output cmd_ctrl_t     rsp_ctrl,
    output back_status_t  back_status
);

    localparam int DEPTH = 1 << AW;
    localparam int CW    = COUNT_WIDTH;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [CW-1:0]  mem [DEPTH];
    logic [CW-1:0]  rd_data_reg;
    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    logic [AW-1:0]  clr_cnt_reg;
    cmd_ctrl_t      ctrl_reg;
    logic [AW-1:0]  addr_reg;
    logic [31:0]    total_reg;
    logic [LW-1:0]  maxlen_reg;

    logic           issue;
    logic           clearing;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [CW-1:0]  mem_wdata;
    logic [CW-1:0]  inc_val;
    logic [CW-1:0]  result;
    logic [CW+31:0] result_x;

    assign clearing = (state_reg == S_CLEAR);
    assign issue    = (state_reg == S_IDLE) && !cmd_empty && !rsp_full;
    assign cmd_pop  = issue;
    assign rsp_push = (state_reg == S_UPDATE);

    assign back_status.clearing = clearing;

    assign inc_val   = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
    assign mem_we    = clearing || (rsp_push && (ctrl_reg.kind == CMD_INC));
    assign mem_waddr = clearing ? clr_cnt_reg : addr_reg;
    assign mem_wdata = clearing ? '0 : inc_val;

    always_comb
    begin
        unique case (ctrl_reg.kind)
            CMD_INC:  result = inc_val;
            CMD_READ: result = rd_data_reg;
            default:  result = '0;
        endcase
    end

    // Saturate to the 32-bit result field
    assign result_x   = (CW + 32)'(result);
    assign rsp_bin    = (|result_x[CW+31:32]) ? 32'hFFFF_FFFF : result_x[31:0];
    assign rsp_total  = total_reg;
    assign rsp_maxlen = maxlen_reg;
    assign rsp_ctrl   = ctrl_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[cmd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ctrl_reg   <= cmd_ctrl;
            addr_reg   <= cmd_addr;
            total_reg  <= cmd_total;
            maxlen_reg <= cmd_maxlen;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (issue)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

endmodule

FILE: design/per_position_quality_histogram.sv
// Top level of the per-position quality histogram: front, command queue, back end with
// the bin memory, result queue. Depends on ppqh_pkg, the submodules, the macros header.
//
//  channel   direction  handshake             fields
//  input     in         push / full           opcode mate quality_char last_in_read
//                                             query_position query_score
//  result    out        empty / pop           bin_count reads_counted longest_read
//                                             mate2_seen score_clamped position_dropped
//  config    in         cfg_wr_en             cfg_wr_data (quality_offset)
//
// The back end reads an item's bin in S_IDLE, then writes it back and transfers the
// result in S_UPDATE, and takes no new item before it is through with the last one.
// After reset a clearing pass zeroes 2 * 2^clog2(MAX_LEN) * 2^clog2(NUM_SCORES)
// entries, one per cycle (32768 entries at the defaults); full stays high meanwhile.
// The command and result queues hold two entries each, so either side may stall.
`timescale 1ns / 1ps
`include "per_position_quality_histogram_macros.svh"

module per_position_quality_histogram
    import ppqh_pkg::*;
#(
    parameter int MAX_LEN     = 256,
    parameter int NUM_SCORES  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic        mate,
    input  logic [7:0]  quality_char,
    input  logic        last_in_read,
    input  logic [7:0]  query_position,
    input  logic [5:0]  query_score,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] bin_count,
    output logic [31:0] reads_counted,
    output logic [8:0]  longest_read,
    output logic        mate2_seen,
    output logic        score_clamped,
    output logic        position_dropped,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int PW    = $clog2(MAX_LEN);
    localparam int SW    = $clog2(NUM_SCORES);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int AW    = 1 + PW + SW;
    localparam int CTL_W = $bits(cmd_ctrl_t);
    localparam int CMD_W = CTL_W + AW + 32 + LW;
    localparam int RSP_W = CTL_W + 32 + 32 + LW;

    back_status_t  back_status;

    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;
    cmd_ctrl_t     f_ctrl;
    logic [AW-1:0] f_addr;
    logic [31:0]   f_total;
    logic [LW-1:0] f_maxlen;
    logic [CMD_W-1:0] cmd_wdata;
    logic [CMD_W-1:0] cmd_rdata;
    cmd_ctrl_t     b_ctrl;
    logic [AW-1:0] b_addr;
    logic [31:0]   b_total;
    logic [LW-1:0] b_maxlen;

    logic          rsp_push;
    logic          rsp_full;
    logic [31:0]   r_bin;
    logic [31:0]   r_total;
    logic [LW-1:0] r_maxlen;
    cmd_ctrl_t     r_ctrl;
    logic [RSP_W-1:0] rsp_wdata;
    logic [RSP_W-1:0] rsp_rdata;
    cmd_ctrl_t     o_ctrl;
    logic [LW-1:0] o_maxlen;
    logic [LW+8:0] o_maxlen_x;

    ppqh_front #(
        .MAX_LEN    (MAX_LEN),
        .NUM_SCORES (NUM_SCORES),
        .PW         (PW),
        .SW         (SW),
        .LW         (LW),
        .AW         (AW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .mate           (mate),
        .quality_char   (quality_char),
        .last_in_read   (last_in_read),
        .query_position (query_position),
        .query_score    (query_score),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .back_status    (back_status),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd_ctrl       (f_ctrl),
        .cmd_addr       (f_addr),
        .cmd_total      (f_total),
        .cmd_maxlen     (f_maxlen)
    );

    assign cmd_wdata = {f_ctrl, f_addr, f_total, f_maxlen};

    ppqh_fifo #(
        .W     (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wdata),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    assign {b_ctrl, b_addr, b_total, b_maxlen} = cmd_rdata;

    ppqh_back #(
        .AW          (AW),
        .COUNT_WIDTH (COUNT_WIDTH),
        .LW          (LW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cmd_ctrl    (b_ctrl),
        .cmd_addr    (b_addr),
        .cmd_total   (b_total),
        .cmd_maxlen  (b_maxlen),
        .rsp_full    (rsp_full),
        .rsp_push    (rsp_push),
        .rsp_bin     (r_bin),
        .rsp_total   (r_total),
        .rsp_maxlen  (r_maxlen),
        .rsp_ctrl    (r_ctrl),
        .back_status (back_status)
    );

    assign rsp_wdata = {r_ctrl, r_bin, r_total, r_maxlen};

    ppqh_fifo #(
        .W     (RSP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rsp_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rsp_push),
        .wr_data (rsp_wdata),
        .rd_en   (pop),
        .rd_data (rsp_rdata),
        .full    (rsp_full),
        .empty   (empty)
    );

    assign {o_ctrl, bin_count, reads_counted, o_maxlen} = rsp_rdata;

    assign o_maxlen_x       = (LW + 9)'(o_maxlen);
    assign longest_read     = o_maxlen_x[8:0];
    assign mate2_seen       = o_ctrl.mate2;
    assign score_clamped    = o_ctrl.clamped;
    assign position_dropped = o_ctrl.dropped;

    `PPQH_ASSERT_IMPL(a_full_while_clearing, back_status.clearing, full)
    `PPQH_ASSERT_IMPL(a_rsp_no_overflow, rsp_push, !rsp_full)
    `PPQH_ASSERT_NEXT(a_issue_then_transfer, cmd_pop, rsp_push)
    `PPQH_ASSERT_IMPL(a_dropped_reads_zero, !empty && position_dropped, bin_count == 32'd0)

endmodule

FILE: bench/per_position_quality_histogram_tb.sv
// Self-checking bench for per_position_quality_histogram: a directed table, then random
// reads, bin queries and empty reads under several quality offsets, stalls and back-pressure.
// Depends on ppqh_pkg and the block's RTL.
`timescale 1ns / 1ps

module per_position_quality_histogram_tb
    import ppqh_pkg::*;
();

    localparam int HIST_POSITIONS = 256;
    localparam int HIST_SCORES    = 64;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int STALL_CYCLES   = 120;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       mate;
        logic [7:0] qchar;
        logic       last;
        logic [7:0] qpos;
        logic [5:0] qscore;
    } qual_item_t;

    typedef struct packed {
        logic [31:0] bin;
        logic [31:0] reads;
        logic [8:0]  longest;
        logic        mate2;
        logic        clamped;
        logic        dropped;
    } hist_result_t;

    typedef struct packed {
        qual_item_t   item;
        logic         typed;
        hist_result_t want;
    } stim_row_t;

    localparam int ITEM_BITS = $bits(qual_item_t);

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [1:0]  opcode         = 2'd0;
    logic        mate           = 1'b0;
    logic [7:0]  quality_char   = 8'd0;
    logic        last_in_read   = 1'b0;
    logic [7:0]  query_position = 8'd0;
    logic [5:0]  query_score    = 6'd0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [31:0] bin_count;
    logic [31:0] reads_counted;
    logic [8:0]  longest_read;
    logic        mate2_seen;
    logic        score_clamped;
    logic        position_dropped;
    logic        cfg_wr_en      = 1'b0;
    logic [7:0]  cfg_wr_data    = 8'd0;

    // Shadow copy of the histogram and its totals
    logic [31:0] model_bins [0:2*HIST_POSITIONS*HIST_SCORES-1];
    logic [8:0]  model_position;
    logic [8:0]  model_longest;
    logic [31:0] model_reads;
    logic        model_mate2;
    logic [7:0]  model_offset;
    logic        recent_mate;
    logic [7:0]  recent_pos;
    logic [5:0]  recent_score;

    hist_result_t pending_stats [$];
    stim_row_t    directed_rows [20];
    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    per_position_quality_histogram DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .opcode           (opcode),
        .mate             (mate),
        .quality_char     (quality_char),
        .last_in_read     (last_in_read),
        .query_position   (query_position),
        .query_score      (query_score),
        .empty            (empty),
        .pop              (pop),
        .bin_count        (bin_count),
        .reads_counted    (reads_counted),
        .longest_read     (longest_read),
        .mate2_seen       (mate2_seen),
        .score_clamped    (score_clamped),
        .position_dropped (position_dropped),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_read();
        if (model_reads != 32'hFFFF_FFFF)
            model_reads = model_reads + 1;
        model_position = 9'd0;
    endfunction

    function automatic hist_result_t histogram_update(qual_item_t it);
        hist_result_t r;
        int score;
        int idx;
        logic [5:0] slot_score;
        r = '0;
        if (it.op == OP_BASE)
        begin
            score = int'({24'd0, it.qchar}) - int'({24'd0, model_offset});
            if (score < 0)
            begin
                slot_score = 6'd0;
                r.clamped  = 1'b1;
            end
            else if (score >= HIST_SCORES)
            begin
                slot_score = 6'(HIST_SCORES - 1);
                r.clamped  = 1'b1;
            end
            else
            begin
                slot_score = 6'(score);
            end
            if (it.mate)
                model_mate2 = 1'b1;
            if (model_position >= HIST_POSITIONS)
            begin
                r.dropped = 1'b1;
            end
            else
            begin
                idx = (int'(it.mate) * HIST_POSITIONS + int'(model_position)) * HIST_SCORES
                      + int'(slot_score);
                if (model_bins[idx] != 32'hFFFF_FFFF)
                    model_bins[idx] = model_bins[idx] + 1;
                r.bin        = model_bins[idx];
                recent_mate  = it.mate;
                recent_pos   = model_position[7:0];
                recent_score = slot_score;
                model_position = model_position + 1;
            end
            if (model_position > model_longest)
                model_longest = model_position;
            if (it.last)
                close_read();
        end
        else if (it.op == OP_QUERY)
        begin
            r.bin = model_bins[(int'(it.mate) * HIST_POSITIONS + int'(it.qpos)) * HIST_SCORES
                               + int'(it.qscore)];
        end
        else if (it.op == OP_EMPTY)
        begin
            close_read();
        end
        r.reads   = model_reads;
        r.longest = model_longest;
        r.mate2   = model_mate2;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Hold push high across back-to-back transfers; lower it only for an idle gap.
    task automatic send_item(input qual_item_t it, input logic typed, input hist_result_t want);
        hist_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        opcode         <= it.op;
        mate           <= it.mate;
        quality_char   <= it.qchar;
        last_in_read   <= it.last;
        query_position <= it.qpos;
        query_score    <= it.qscore;
        do @(posedge clk); while (full);
        predicted = histogram_update(it);
        pending_stats.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        model_offset  = value;
    endtask

    // Mostly well-formed reads with random qualities, plus queries, empty reads and noise.
    task automatic send_random_traffic(input int item_target, input bit with_long_read);
        qual_item_t it;
        int sent;
        int roll;
        int bases_in_read;
        bit close_by_empty;
        sent = 0;
        while (sent < item_target)
        begin
            roll = with_long_read ? 0 : int'($urandom_range(99));
            it = ITEM_BITS'($urandom);
            if (roll < 58)
            begin
                if (with_long_read)
                begin
                    bases_in_read = HIST_POSITIONS + $urandom_range(1, 6);
                    with_long_read = 1'b0;
                end
                else if ($urandom_range(9) == 0)
                    bases_in_read = $urandom_range(25, 60);
                else
                    bases_in_read = $urandom_range(1, 16);
                close_by_empty = ($urandom_range(9) == 0);
                for (int k = 0; k < bases_in_read; k++)
                begin
                    it.op     = OP_BASE;
                    it.qpos   = 8'($urandom);
                    it.qscore = 6'($urandom);
                    if ($urandom_range(9) == 0)
                        it.mate = ~it.mate;
                    if ($urandom_range(3) == 0)
                        it.qchar = 8'($urandom);
                    else
                        it.qchar = model_offset + 8'($urandom_range(63));
                    it.last = (k == bases_in_read - 1) && !close_by_empty;
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                if (close_by_empty)
                begin
                    it    = ITEM_BITS'($urandom);
                    it.op = OP_EMPTY;
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                if (roll < 85)
                begin
                    it.op = OP_QUERY;
                    if ($urandom_range(1) == 1)
                    begin
                        it.mate   = recent_mate;
                        it.qpos   = recent_pos;
                        it.qscore = recent_score;
                    end
                    else if ($urandom_range(1) == 1)
                        it.qpos = 8'($urandom_range(31));
                end
                else if (roll < 92)
                    it.op = OP_EMPTY;
                else if (roll < 95)
                    it.op = OP_UNUSED;
                else
                    it.op = OP_BASE;
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result side: check each transfer, then choose pop for the next edge.
    always @(posedge clk)
    begin
        hist_result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_stats.size() == 0)
                begin
                    $error("result with nothing expected, bin_count %0d", bin_count);
                    error_count++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    check_field("bin_count", want.bin, bin_count);
                    check_field("reads_counted", want.reads, reads_counted);
                    check_field("longest_read", 32'(want.longest), 32'(longest_read));
                    check_field("mate2_seen", 32'(want.mate2), 32'(mate2_seen));
                    check_field("score_clamped", 32'(want.clamped), 32'(score_clamped));
                    check_field("position_dropped", 32'(want.dropped), 32'(position_dropped));
                end
            end
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                stall_left   = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        directed_rows = '{
            '{'{OP_QUERY,  1'b0, 8'd0,   1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd0, 32'd0, 9'd0, 1'b0, 1'b0, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd0,   1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd1, 32'd0, 9'd1, 1'b0, 1'b1, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd255, 1'b0, 8'd255, 6'd63}, 1'b1,
              '{32'd1, 32'd0, 9'd2, 1'b0, 1'b1, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd33,  1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd1, 32'd0, 9'd3, 1'b0, 1'b0, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd96,  1'b1, 8'd0,   6'd0},  1'b1,
              '{32'd1, 32'd1, 9'd4, 1'b0, 1'b0, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd32,  1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd2, 32'd1, 9'd4, 1'b0, 1'b1, 1'b0}},
            // mate switches mid-read; position carries on
            '{'{OP_BASE,   1'b1, 8'd97,  1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd1, 32'd1, 9'd4, 1'b1, 1'b1, 1'b0}},
            '{'{OP_BASE,   1'b0, 8'd60,  1'b1, 8'd0,   6'd0},  1'b1,
              '{32'd1, 32'd2, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_EMPTY,  1'b0, 8'd0,   1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd0, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_UNUSED, 1'b1, 8'd255, 1'b1, 8'd255, 6'd63}, 1'b1,
              '{32'd0, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_QUERY,  1'b0, 8'd0,   1'b0, 8'd0,   6'd0},  1'b1,
              '{32'd2, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_QUERY,  1'b1, 8'd0,   1'b0, 8'd1,   6'd63}, 1'b1,
              '{32'd1, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_QUERY,  1'b1, 8'd255, 1'b1, 8'd255, 6'd63}, 1'b1,
              '{32'd0, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_QUERY,  1'b0, 8'd0,   1'b0, 8'd3,   6'd63}, 1'b1,
              '{32'd1, 32'd3, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_EMPTY,  1'b1, 8'd255, 1'b1, 8'd255, 6'd63}, 1'b1,
              '{32'd0, 32'd4, 9'd4, 1'b1, 1'b0, 1'b0}},
            '{'{OP_BASE,   1'b1, 8'hAA,  1'b0, 8'h55,  6'h2A}, 1'b0, '0},
            '{'{OP_BASE,   1'b0, 8'h55,  1'b0, 8'hAA,  6'h15}, 1'b0, '0},
            // empty read in the middle of a read restarts the position
            '{'{OP_EMPTY,  1'b0, 8'd0,   1'b0, 8'd0,   6'd0},  1'b0, '0},
            '{'{OP_QUERY,  1'b1, 8'd0,   1'b0, 8'd0,   6'd63}, 1'b0, '0},
            '{'{OP_QUERY,  1'b0, 8'd0,   1'b0, 8'd1,   6'd52}, 1'b0, '0}
        };
        for (int i = 0; i < 2 * HIST_POSITIONS * HIST_SCORES; i++)
            model_bins[i] = 32'd0;
        model_position = 9'd0;
        model_longest  = 9'd0;
        model_reads    = 32'd0;
        model_mate2    = 1'b0;
        model_offset   = OFFSET_RESET;
        recent_mate    = 1'b0;
        recent_pos     = 8'd0;
        recent_score   = 6'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 62;
        write_offset(OFFSET_RESET);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        drain_results();
        write_offset(8'd64);
        send_random_traffic(160, 1'b0);

        drain_results();
        send_idle_pct = 62;
        recv_idle_pct = 33;
        write_offset(8'd0);
        send_random_traffic(160, 1'b0);

        // stall the result side while items keep coming
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_offset(8'd255);
        stall_requests++;
        send_random_traffic(110, 1'b0);

        drain_results();
        write_offset(8'($urandom_range(1, 254)));
        send_random_traffic(270, 1'b1);

        drain_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/ppqh_pkg.sv
design/ppqh_fifo.sv
design/ppqh_front.sv
design/ppqh_back.sv
design/per_position_quality_histogram.sv
bench/per_position_quality_histogram_tb.sv
